[hdl/bsd_pkg.sv]
package bsd_pkg;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LIST = 2'd2;

  typedef logic [2:0] uaddr_t;
  typedef logic [2:0] op_t;
  typedef logic [1:0] cond_t;

  localparam uaddr_t UA_IDLE  = 3'd0;
  localparam uaddr_t UA_PUSH  = 3'd1;
  localparam uaddr_t UA_POP   = 3'd2;
  localparam uaddr_t UA_LIST  = 3'd3;
  localparam uaddr_t UA_LLOOP = 3'd4;

  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_PUSH   = 3'd1;
  localparam op_t OP_POP    = 3'd2;
  localparam op_t OP_LSTART = 3'd3;
  localparam op_t OP_LSTEP  = 3'd4;

  localparam cond_t COND_NONE     = 2'd0;
  localparam cond_t COND_CNT_ZERO = 2'd1;
  localparam cond_t COND_REM_ONE  = 2'd2;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t seq;
    uaddr_t jmp;
  } uword_t;

  typedef struct packed {
    logic cnt_zero;
    logic rem_one;
  } flags_t;

endpackage

[hdl/bounded_stack_drop_oldest.sv]
// Channel  Ports                                        Handshake
// in       in_mode, in_push_value                       start high, busy low
// out      out_status, out_entry_value, out_last        out_strobe, one cycle
// cfg      cfg_wr_data                                  cfg_wr_en
//
// Push and pop execute in the cycle the beat is accepted and keep busy low.
// A list holds busy while it steps through the stored entries; its first result
// beat passes through the registered RAM read and then the output register.
// Every result beat is registered and shows in the cycle after it is computed.
// Reset empties the stack and loads the limit of ten; the receiver cannot stall.
module bounded_stack_drop_oldest
  import bsd_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [VALUE_W-1:0] in_push_value,
  output logic                      out_strobe,
  output logic                      out_status,
  output logic signed [VALUE_W-1:0] out_entry_value,
  output logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [LIMIT_W-1:0]        cfg_wr_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] TOP_MAX = AW'(CAPACITY - 1);

  uword_t uword;
  flags_t flags;

  logic [LIMIT_W-1:0]    limit_r;
  logic [AW-1:0]         top_r, top_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         cursor_r, cursor_nxt;
  logic [CW-1:0]         remain_r, remain_nxt;

  logic                  strobe_r, strobe_nxt;
  logic                  status_r, status_nxt;
  logic                  last_r, last_nxt;
  logic [VALUE_W-1:0]    value_r, value_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [LW-1:0]         lim_ext;
  logic [CW-1:0]         eff_limit;
  logic [AW-1:0]         top_inc, top_dec, cursor_dec;

  bsd_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .flags (flags),
    .uword (uword),
    .busy  (busy)
  );

  bsd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (top_inc),
    .wdata (DATA_WIDTH'($unsigned(in_push_value))),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign flags.cnt_zero = (count_r == '0);
  assign flags.rem_one  = (remain_r == CW'(1));

  assign lim_ext = LW'(limit_r);

  always_comb begin
    if (lim_ext == '0) begin
      eff_limit = CW'(1);
    end else if (lim_ext > LW'(CAPACITY)) begin
      eff_limit = CW'(CAPACITY);
    end else begin
      eff_limit = CW'(lim_ext);
    end
  end

  assign top_inc    = (top_r == TOP_MAX) ? '0 : top_r + 1'b1;
  assign top_dec    = (top_r == '0) ? TOP_MAX : top_r - 1'b1;
  assign cursor_dec = (cursor_r == '0) ? TOP_MAX : cursor_r - 1'b1;

  always_comb begin
    top_nxt    = top_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    remain_nxt = remain_r;
    ram_we     = 1'b0;
    ram_raddr  = top_r;
    strobe_nxt = 1'b0;
    status_nxt = 1'b0;
    last_nxt   = 1'b0;
    value_nxt  = '0;
    case (uword.op)
      OP_PUSH: begin
        ram_we     = 1'b1;
        top_nxt    = top_inc;
        count_nxt  = (count_r >= eff_limit) ? eff_limit : count_r + 1'b1;
        strobe_nxt = 1'b1;
        status_nxt = 1'b1;
        last_nxt   = 1'b1;
      end
      OP_POP: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        if (count_r != '0) begin
          status_nxt = 1'b1;
          top_nxt    = top_dec;
          count_nxt  = count_r - 1'b1;
        end
      end
      OP_LSTART: begin
        if (count_r == '0) begin
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
        end else begin
          cursor_nxt = top_r;
          remain_nxt = count_r;
        end
      end
      OP_LSTEP: begin
        strobe_nxt = 1'b1;
        status_nxt = 1'b1;
        value_nxt  = VALUE_W'(ram_rdata);
        last_nxt   = (remain_r == CW'(1));
        ram_raddr  = cursor_dec;
        cursor_nxt = cursor_dec;
        remain_nxt = remain_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      top_r    <= '0;
      count_r  <= '0;
      remain_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      top_r    <= top_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    value_r  <= value_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_last        = last_r;
  assign out_entry_value = value_r;

endmodule

[hdl/bsd_ram.sv]
module bsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bsd_useq.sv]
module bsd_useq
  import bsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  flags_t            flags,
  output uword_t            uword,
  output logic              busy
);

  uaddr_t upc_r;
  uaddr_t upc_nxt;
  uaddr_t uaddr;
  logic   take;

  function automatic uword_t rom(input uaddr_t a);
    uword_t w;
    case (a)
      UA_IDLE:  w = '{op: OP_NOP,    cond: COND_NONE,     seq: UA_IDLE,  jmp: UA_IDLE};
      UA_PUSH:  w = '{op: OP_PUSH,   cond: COND_NONE,     seq: UA_IDLE,  jmp: UA_IDLE};
      UA_POP:   w = '{op: OP_POP,    cond: COND_NONE,     seq: UA_IDLE,  jmp: UA_IDLE};
      UA_LIST:  w = '{op: OP_LSTART, cond: COND_CNT_ZERO, seq: UA_LLOOP, jmp: UA_IDLE};
      UA_LLOOP: w = '{op: OP_LSTEP,  cond: COND_REM_ONE,  seq: UA_LLOOP, jmp: UA_IDLE};
      default:  w = '{op: OP_NOP,    cond: COND_NONE,     seq: UA_IDLE,  jmp: UA_IDLE};
    endcase
    return w;
  endfunction

  assign busy = (upc_r != UA_IDLE);

  always_comb begin
    uaddr = upc_r;
    if (!busy) begin
      uaddr = UA_IDLE;
      if (start) begin
        case (mode)
          MODE_PUSH: uaddr = UA_PUSH;
          MODE_POP:  uaddr = UA_POP;
          MODE_LIST: uaddr = UA_LIST;
          default:   uaddr = UA_IDLE;
        endcase
      end
    end
  end

  assign uword = rom(uaddr);

  always_comb begin
    case (uword.cond)
      COND_CNT_ZERO: take = flags.cnt_zero;
      COND_REM_ONE:  take = flags.rem_one;
      default:       take = 1'b0;
    endcase
    upc_nxt = take ? uword.jmp : uword.seq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[tb/sv/stack_checker.sv]
`timescale 1ns / 100ps
module stack_checker
  import bsd_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [VALUE_W-1:0] in_push_value,
  input  logic                      out_strobe,
  input  logic                      out_status,
  input  logic signed [VALUE_W-1:0] out_entry_value,
  input  logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [LIMIT_W-1:0]        cfg_wr_data,
  output int                        fail_count,
  output int                        pending_count
);

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value;
    logic               last;
  } stack_result_t;

  stack_result_t      pending_results[$];
  logic [VALUE_W-1:0] entry_store[CAPACITY];
  int unsigned        top_index;
  int unsigned        entry_count;
  logic [LIMIT_W-1:0] depth_limit;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    top_index     = 0;
    entry_count   = 0;
    depth_limit   = LIMIT_RESET;
  end

  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = depth_limit;
    if (lim == 0) lim = 1;
    if (lim > CAPACITY) lim = CAPACITY;
    return lim;
  endfunction

  function automatic stack_result_t make_result(logic status, logic [VALUE_W-1:0] value,
                                                logic last);
    stack_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    return r;
  endfunction

  task automatic apply_stack_op(input logic [MODE_W-1:0] mode,
                                input logic [VALUE_W-1:0] value);
    int unsigned lim;
    int unsigned slot;
    lim = active_limit();
    case (mode)
      MODE_PUSH: begin
        if (entry_count >= lim) entry_count = lim - 1;
        top_index = (top_index + 1) % CAPACITY;
        entry_store[top_index] = value;
        entry_count++;
        pending_results.push_back(make_result(1'b1, '0, 1'b1));
      end
      MODE_POP: begin
        if (entry_count == 0) begin
          pending_results.push_back(make_result(1'b0, '0, 1'b1));
        end else begin
          top_index = (top_index + CAPACITY - 1) % CAPACITY;
          entry_count--;
          pending_results.push_back(make_result(1'b1, '0, 1'b1));
        end
      end
      MODE_LIST: begin
        if (entry_count == 0) begin
          pending_results.push_back(make_result(1'b0, '0, 1'b1));
        end else begin
          slot = top_index;
          for (int i = 0; i < entry_count; i++) begin
            pending_results.push_back(make_result(1'b1, entry_store[slot],
                                                  (i + 1 == entry_count)));
            slot = (slot + CAPACITY - 1) % CAPACITY;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result_beat();
    stack_result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("Unexpected result beat: status %0d value %h last %0d",
                 out_status, out_entry_value, out_last);
      return;
    end
    want = pending_results.pop_front();
    if (out_status !== want.status || out_entry_value !== want.value ||
        out_last !== want.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display("Result mismatch: expected status %0d value %h last %0d, got %0d %h %0d",
                 want.status, want.value, want.last,
                 out_status, out_entry_value, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      top_index   = 0;
      entry_count = 0;
      depth_limit = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (out_strobe) check_result_beat();
      if (cfg_wr_en) depth_limit = cfg_wr_data;
      if (start && !busy) apply_stack_op(in_mode, in_push_value);
    end
    pending_count = pending_results.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import bsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode = MODE_PUSH;
  logic signed [VALUE_W-1:0] in_push_value = '0;
  logic                      out_strobe;
  logic                      out_status;
  logic signed [VALUE_W-1:0] out_entry_value;
  logic                      out_last;
  logic                      cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]        cfg_wr_data = '0;
  int                        fail_count;
  int                        pending_count;
  int                        cycle_count;
  int                        push_beats = 0;
  int                        pop_beats = 0;
  int                        list_beats = 0;
  int                        ignored_beats = 0;
  int                        limit_writes = 0;

  always #10 clk = ~clk;

  bounded_stack_drop_oldest #(
    .CAPACITY  (16),
    .DATA_WIDTH(32)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_push_value  (in_push_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_entry_value(out_entry_value),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  stack_checker #(
    .CAPACITY(16)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_push_value  (in_push_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_entry_value(out_entry_value),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_count);
    $display("status: fail");
    $finish;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Holds the beat on the input ports until the block takes it.
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
    in_mode       = mode;
    in_push_value = value;
    start         = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    case (mode)
      MODE_PUSH: push_beats++;
      MODE_POP:  pop_beats++;
      MODE_LIST: list_beats++;
      default:   ignored_beats++;
    endcase
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = limit;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    limit_writes++;
  endtask

  task automatic run_random(input int n_items, input int push_weight, input bit no_gaps);
    int done;
    int r;
    logic [MODE_W-1:0] mode;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < push_weight) mode = MODE_PUSH;
      else if (r >= 96) mode = MODE_UNUSED;
      else if ($urandom_range(0, 2) == 0) mode = MODE_LIST;
      else mode = MODE_POP;
      send_op(mode, pick_value());
      if (mode != MODE_UNUSED) done++;
      if (!no_gaps) idle_cycles(gap_length());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_op(MODE_POP, '0);
    send_op(MODE_LIST, '0);
    send_op(MODE_PUSH, 32'h7fff_ffff);
    send_op(MODE_PUSH, 32'h8000_0000);
    send_op(MODE_PUSH, 32'h0000_0000);
    send_op(MODE_PUSH, 32'hffff_ffff);
    send_op(MODE_LIST, '0);
    send_op(MODE_UNUSED, 32'h1234_5678);
    send_op(MODE_POP, '0);
    send_op(MODE_LIST, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);

    // The reset limit of ten must drop the oldest entry once the stack is full.
    run_random(20, 80, 1'b0);

    write_limit(5'd1);
    send_op(MODE_PUSH, 32'h5a5a_5a5a);
    send_op(MODE_PUSH, 32'ha5a5_a5a5);
    send_op(MODE_LIST, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_LIST, '0);

    write_limit(5'd16);
    run_random(24, 75, 1'b0);
    // Lowering the limit below the count leaves entries visible until the next push.
    write_limit(5'd3);
    send_op(MODE_LIST, '0);
    run_random(18, 40, 1'b0);
    write_limit(5'd0);
    run_random(16, 50, 1'b0);
    write_limit(5'd31);
    run_random(24, 70, 1'b1);
    write_limit(5'd2);
    run_random(16, 45, 1'b0);
    write_limit(5'($urandom_range(4, 15)));
    run_random(20, 55, 1'b0);
    write_limit(5'($urandom_range(0, 31)));
    run_random(20, 50, 1'b0);

    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d push, %0d pop and %0d list beats, plus %0d beats of the unused mode.",
             push_beats, pop_beats, list_beats, ignored_beats);
    $display("Depth limit written %0d times, including 0, 1, 2, 3, 16 and 31; %0d failures.",
             limit_writes, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
